FILE: rtl/sha256_stream_hash_core_assert.svh
// ----------------------------------------------------------------------------
// sha256 stream hash assertion macros
// shared concurrent assertion forms for the hash core
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASH_CORE_ASSERT_SVH
`define SHA256_STREAM_HASH_CORE_ASSERT_SVH

// same-cycle implication
`define SSH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sha256sh_pkg.sv
// ----------------------------------------------------------------------------
// sha256sh_pkg
// types, round constants and round functions of the sha-256 hash core
// ----------------------------------------------------------------------------
package sha256sh_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned DigestWords = 8;

  localparam byte_t PAD_MARK = 8'h80;

  localparam word_t ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_H [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

FILE: rtl/sha256_stream_hash_core.sv
// a byte beat is absorbed whenever in_ready is high, in the idle state
// a beat that completes a 64-byte block holds ready low through the rounds and the add
// end of message: pad bytes fill the block, then rounds and add, once or twice, then 8 digest beats
// one round per cycle through a single shared round unit; pad bytes enter one per cycle
// synchronous active-low reset loads the initial hash words and clears counts;
// the block buffer is not cleared
// ----------------------------------------------------------------------------
// sha256_stream_hash_core
// byte-serial sha-256 engine with padding and word-serial digest output
// ----------------------------------------------------------------------------
`include "sha256_stream_hash_core_assert.svh"

module sha256_stream_hash_core import sha256sh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_RND = 6'd63;
  localparam logic [2:0] LAST_IDX = 3'd7;

  state_t      state_r, state_nxt;
  word_t       chain_r [DigestWords];
  word_t       chain_nxt [DigestWords];
  word_t       w_r [16];
  word_t       w_nxt [16];
  word_t       v_r [8];
  word_t       v_nxt [8];
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bitcnt_r, bitcnt_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        pad_act_r, pad_act_nxt;
  logic        mark_r, mark_nxt;
  logic        wrap_r, wrap_nxt;
  logic        last_r, last_nxt;

  logic        shift_en;
  byte_t       shift_byte;
  logic        len_phase;
  logic [63:0] len_shift;
  word_t       t1, t2, sched;

  assign len_phase = mark_r && !wrap_r && (fill_r >= LEN_POS);
  assign len_shift = bitcnt_r >> {3'd7 - fill_r[2:0], 3'b000};

  // shared round unit
  always_comb begin
    t1 = v_r[7] + big_sigma1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + ROUND_K[rnd_r] + w_r[0];
    t2 = big_sigma0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    sched = w_r[0] + small_sigma0(w_r[1]) + w_r[9] + small_sigma1(w_r[14]);
  end

  always_comb begin
    state_nxt   = state_r;
    chain_nxt   = chain_r;
    w_nxt       = w_r;
    v_nxt       = v_r;
    fill_nxt    = fill_r;
    bitcnt_nxt  = bitcnt_r;
    rnd_nxt     = rnd_r;
    idx_nxt     = idx_r;
    pad_act_nxt = pad_act_r;
    mark_nxt    = mark_r;
    wrap_nxt    = wrap_r;
    last_nxt    = last_r;
    shift_en    = 1'b0;
    shift_byte  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_has_byte) begin
            shift_en   = 1'b1;
            shift_byte = in_data_byte;
            fill_nxt   = fill_r + 6'd1;
            bitcnt_nxt = bitcnt_r + 64'd8;
          end
          if (in_end_of_message) begin
            pad_act_nxt = 1'b1;
          end
          if (in_has_byte && fill_r == LAST_POS) begin
            state_nxt = S_ROUND;
            rnd_nxt   = '0;
            v_nxt     = chain_r;
          end else if (in_end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        shift_en = 1'b1;
        fill_nxt = fill_r + 6'd1;
        if (!mark_r) begin
          shift_byte = PAD_MARK;
          mark_nxt   = 1'b1;
        end else if (len_phase) begin
          shift_byte = len_shift[7:0];
        end
        if (fill_r == LAST_POS) begin
          wrap_nxt = 1'b0;
        end else if (!mark_r) begin
          wrap_nxt = (fill_r >= LEN_POS);
        end
        if (fill_r == LAST_POS) begin
          state_nxt = S_ROUND;
          rnd_nxt   = '0;
          v_nxt     = chain_r;
          last_nxt  = len_phase;
        end
      end
      S_ROUND: begin
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = sched;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == LAST_RND) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < DigestWords; i++) begin
          chain_nxt[i] = chain_r[i] + v_r[i];
        end
        if (last_r) begin
          state_nxt = S_OUT;
          idx_nxt   = '0;
        end else if (pad_act_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          for (int i = 0; i < DigestWords - 1; i++) begin
            chain_nxt[i] = chain_r[i+1];
          end
          chain_nxt[DigestWords-1] = chain_r[0];
          if (idx_r == LAST_IDX) begin
            chain_nxt   = INIT_H;
            fill_nxt    = '0;
            bitcnt_nxt  = '0;
            pad_act_nxt = 1'b0;
            mark_nxt    = 1'b0;
            wrap_nxt    = 1'b0;
            last_nxt    = 1'b0;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // byte beats enter at the low end of the 512-bit window
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = {w_r[i][23:0], w_r[i+1][31:24]};
      end
      w_nxt[15] = {w_r[15][23:0], shift_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      chain_r   <= INIT_H;
      fill_r    <= '0;
      bitcnt_r  <= '0;
      rnd_r     <= '0;
      idx_r     <= '0;
      pad_act_r <= 1'b0;
      mark_r    <= 1'b0;
      wrap_r    <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chain_r   <= chain_nxt;
      fill_r    <= fill_nxt;
      bitcnt_r  <= bitcnt_nxt;
      rnd_r     <= rnd_nxt;
      idx_r     <= idx_nxt;
      pad_act_r <= pad_act_nxt;
      mark_r    <= mark_nxt;
      wrap_r    <= wrap_nxt;
      last_r    <= last_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    v_r <= v_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = chain_r[0];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == LAST_IDX);

  `SSH_ASSERT_NOW(a_no_overlap, clk, rst_n, in_ready, !out_valid, "ready during digest output")
  `SSH_ASSERT_NEXT(a_block_start, clk, rst_n,
    in_valid && in_ready && in_has_byte && fill_r == LAST_POS,
    state_r == S_ROUND && rnd_r == 6'd0, "full block did not start rounds")
  `SSH_ASSERT_NEXT(a_round_end, clk, rst_n, state_r == S_ROUND && rnd_r == LAST_RND,
    state_r == S_ADD, "round count overran")
  `SSH_ASSERT_NEXT(a_msg_restart, clk, rst_n, out_valid && out_ready && out_last_word,
    in_ready && fill_r == 6'd0 && bitcnt_r == 64'd0, "state not cleared after digest")

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hash_core testbench
// streams byte messages of assorted lengths through the hash core under
// random sender bursts and receiver stalls, and checks every digest beat
// against a sha-256 model computed in the bench
// ----------------------------------------------------------------------------
module tb import sha256sh_pkg::*; ();

  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned DrainCycles  = 300;
  localparam int unsigned ByteBudget   = 410;
  localparam byte_t       PadByte      = 8'h80;

  localparam word_t SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    byte_t data;
    logic  has_byte;
    logic  eom;
  } byte_beat_t;

  typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_has_byte = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  byte_beat_t   byte_beats_q[$];
  digest_beat_t digest_words_q[$];
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;

  word_t        hash_words [8];
  byte_t        msg_block [64];
  int unsigned  block_fill;
  logic [63:0]  msg_bits;

  sha256_stream_hash_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_compress();
    word_t sched [64];
    word_t v [8];
    word_t t1;
    word_t t2;
    word_t s0;
    word_t s1;
    for (int t = 0; t < 16; t++) begin
      sched[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
      s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
      sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
    end
    for (int j = 0; j < 8; j++) v[j] = hash_words[j];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + sched[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_words[j] = hash_words[j] + v[j];
  endfunction

  function automatic void hash_restart();
    for (int j = 0; j < 8; j++) hash_words[j] = SHA_IV[j];
    block_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void hash_absorb(input byte_beat_t beat);
    digest_beat_t dw;
    if (beat.has_byte) begin
      msg_block[block_fill] = beat.data;
      block_fill++;
      msg_bits = msg_bits + 64'd8;
      if (block_fill == 64) begin
        sha_compress();
        block_fill = 0;
      end
    end
    if (beat.eom) begin
      msg_block[block_fill] = PadByte;
      for (int j = block_fill + 1; j < 64; j++) msg_block[j] = 8'h00;
      if (block_fill >= 56) begin
        sha_compress();
        for (int j = 0; j < 64; j++) msg_block[j] = 8'h00;
      end
      for (int j = 0; j < 8; j++) msg_block[56+j] = msg_bits[63-8*j -: 8];
      sha_compress();
      for (int j = 0; j < 8; j++) begin
        dw.word  = hash_words[j];
        dw.index = 3'(j);
        dw.last  = (j == 7);
        digest_words_q.push_back(dw);
      end
      hash_restart();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void push_beat(input byte_t data, input logic has, input logic eom);
    byte_beat_t b;
    b.data = data;
    b.has_byte = has;
    b.eom = eom;
    byte_beats_q.push_back(b);
  endfunction

  // random noise beats carry neither a byte nor an end flag
  function automatic void push_message(input int unsigned len);
    logic joined_end;
    joined_end = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_beat(8'($urandom_range(0, 255)), 1'b1, joined_end && (k == len - 1));
    end
    if (!joined_end) push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endfunction

  // sender: bursts of random length separated by random gaps
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      hash_restart();
      for (int j = 0; j < 64; j++) msg_block[j] = 8'h00;
    end else begin
      if (in_valid && in_ready) begin
        hash_absorb('{in_data_byte, in_has_byte, in_end_of_message});
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_beats_q.size() != 0) begin
          in_valid          <= 1'b1;
          in_data_byte      <= byte_beats_q[0].data;
          in_has_byte       <= byte_beats_q[0].has_byte;
          in_end_of_message <= byte_beats_q[0].eom;
          void'(byte_beats_q.pop_front());
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 64);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall mode is drawn anew at random whenever its countdown runs out
  int unsigned stall_mode = 0;
  int unsigned mode_left = 40;

  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_words_q.size() == 0) begin
          report_mismatch("unexpected digest beat", out_digest_word, 32'h0);
        end else begin
          want = digest_words_q.pop_front();
          if (out_digest_word !== want.word)
            report_mismatch("digest_word", out_digest_word, want.word);
          if (out_word_index !== want.index)
            report_mismatch("word_index", 32'(out_word_index), 32'(want.index));
          if (out_last_word !== want.last)
            report_mismatch("last_word", 32'(out_last_word), 32'(want.last));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 150);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ready <= ($urandom_range(0, 7) == 0);
        end
        default: begin
          out_ready <= (mode_left[3:0] < 4'd6);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("sha256_stream_hash_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned lengths[$];
    int unsigned total;
    int unsigned pick;
    int unsigned tmp;

    // empty message, noise, "abc" with byte and end together
    push_beat(8'h5a, 1'b0, 1'b1);
    push_beat(8'hff, 1'b0, 1'b0);
    push_beat(8'h61, 1'b1, 1'b0);
    push_beat(8'h62, 1'b1, 1'b0);
    push_beat(8'h63, 1'b1, 1'b1);
    // single extreme bytes, end alone and end joined, then a two-byte message and an empty one
    push_beat(8'h00, 1'b1, 1'b1);
    push_beat(8'hff, 1'b1, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'hff, 1'b0, 1'b1);
    push_beat(8'h80, 1'b1, 1'b0);
    push_beat(8'h55, 1'b1, 1'b0);
    push_beat(8'haa, 1'b0, 1'b1);
    push_beat(8'h00, 1'b0, 1'b1);

    // padding boundaries plus short messages, shuffled
    lengths = '{55, 56, 63, 64};
    total = 238 + 13;
    while (total < ByteBudget) begin
      pick = $urandom_range(0, 24);
      lengths.push_back(pick);
      total += pick + 1;
    end
    for (int k = lengths.size() - 1; k > 0; k--) begin
      pick = $urandom_range(0, k);
      tmp = lengths[k];
      lengths[k] = lengths[pick];
      lengths[pick] = tmp;
    end
    foreach (lengths[k]) push_message(lengths[k]);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_beats_q.size() != 0 || in_valid) @(posedge clk);
    while (digest_words_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("sha256_stream_hash_core regression: pass");
    end else begin
      $display("sha256_stream_hash_core regression: fail");
    end
    $finish;
  end

endmodule
